// ===== rtl/ntab_pkg.sv =====
// Shared types and constants for the neighbor table with aging.
package ntab_pkg;

  localparam int unsigned ID_W      = 32;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned OUTCOME_W = 3;
  localparam int unsigned LIVE_W    = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd10000;

  localparam logic CMD_OBSERVE = 1'b0;
  localparam logic CMD_AGE     = 1'b1;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_IGNORED   = 3'd0,
    OUT_REFRESHED = 3'd1,
    OUT_ADDED     = 3'd2,
    OUT_DROPPED   = 3'd3,
    OUT_AGED      = 3'd4
  } outcome_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } ntab_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_busy;
  } ntab_stat_t;

endpackage

// ===== rtl/ntab_ctrl.sv =====
// Sequencer for one request: load, purge scan, then the finish step.
module ntab_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  ntab_pkg::ntab_stat_t stat_i,
  output ntab_pkg::ntab_ctrl_t ctrl_o
);
  import ntab_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_q, state_d;

  assign busy = (state_q != ST_IDLE);

  always_comb begin
    state_d       = state_q;
    ctrl_o.load   = 1'b0;
    ctrl_o.scan   = 1'b0;
    ctrl_o.finish = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          ctrl_o.load = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctrl_o.scan = 1'b1;
        if (!stat_i.scan_busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        ctrl_o.finish = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/ntab_datapath.sv =====
// Table memories, configuration registers, purge compaction and observe update.
module ntab_datapath #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ntab_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ntab_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                            command_i,
  input  logic [ntab_pkg::ID_W-1:0]       node_id_i,
  input  logic [ntab_pkg::TIME_W-1:0]     now_ms_i,
  input  ntab_pkg::ntab_ctrl_t            ctrl_i,
  output ntab_pkg::ntab_stat_t            stat_o,
  output logic                            done_o,
  output logic [ntab_pkg::OUTCOME_W-1:0]  outcome_o,
  output logic [ntab_pkg::LIVE_W-1:0]     live_count_o
);
  import ntab_pkg::*;

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

  logic [ID_W-1:0]   ids_mem  [MAX_ENTRIES];
  logic [TIME_W-1:0] seen_mem [MAX_ENTRIES];

  logic [ID_W-1:0]   self_id_q;
  logic [TIME_W-1:0] timeout_q;

  // Request latched at load.
  logic              cmd_q;
  logic [ID_W-1:0]   id_q;
  logic [TIME_W-1:0] now_q;
  logic              ign_q;

  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     rd_q, rd_d;
  logic [CW-1:0]     keep_q, keep_d;
  logic              rd_vld_q, rd_vld_d;
  logic              match_q, match_d;
  logic [AW-1:0]     slot_q, slot_d;

  logic [ID_W-1:0]   rd_id_q;
  logic [TIME_W-1:0] rd_time_q;

  logic              done_q, done_d;
  logic [OUTCOME_W-1:0] outcome_q, outcome_d;
  logic [LIVE_W-1:0] live_q, live_d;

  logic              issue, eval, survive;
  logic [TIME_W-1:0] age;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [ID_W-1:0]   wr_id;
  logic [TIME_W-1:0] wr_time;
  logic [CW+LIVE_W-1:0] cnt_ext;

  assign issue   = ctrl_i.scan && (rd_q < count_q);
  assign eval    = ctrl_i.scan && rd_vld_q;
  assign age     = now_q - rd_time_q;
  assign survive = (age < timeout_q);

  assign stat_o.scan_busy = (rd_q < count_q) || rd_vld_q;

  always_comb begin
    rd_d      = rd_q;
    rd_vld_d  = issue;
    keep_d    = keep_q;
    match_d   = match_q;
    slot_d    = slot_q;
    count_d   = count_q;
    done_d    = 1'b0;
    outcome_d = outcome_q;
    wr_en     = 1'b0;
    wr_addr   = keep_q[AW-1:0];
    wr_id     = rd_id_q;
    wr_time   = rd_time_q;

    if (ctrl_i.load) begin
      rd_d     = '0;
      rd_vld_d = 1'b0;
      keep_d   = '0;
      match_d  = 1'b0;
    end

    if (issue) begin
      rd_d = rd_q + CW'(1);
    end

    // Survivors are packed down to the keep pointer, which never passes the read pointer.
    if (eval && survive) begin
      wr_en  = 1'b1;
      keep_d = keep_q + CW'(1);
      if (!ign_q && !match_q && (rd_id_q == id_q)) begin
        match_d = 1'b1;
        slot_d  = keep_q[AW-1:0];
      end
    end

    if (ctrl_i.finish) begin
      done_d  = 1'b1;
      count_d = keep_q;
      wr_id   = id_q;
      wr_time = now_q;
      if (cmd_q == CMD_AGE) begin
        outcome_d = OUT_AGED;
      end else if (ign_q) begin
        outcome_d = OUT_IGNORED;
      end else if (match_q) begin
        wr_en     = 1'b1;
        wr_addr   = slot_q;
        outcome_d = OUT_REFRESHED;
      end else if (keep_q < MAX_CNT) begin
        wr_en     = 1'b1;
        count_d   = keep_q + CW'(1);
        outcome_d = OUT_ADDED;
      end else begin
        outcome_d = OUT_DROPPED;
      end
    end
  end

  assign cnt_ext = {{LIVE_W{1'b0}}, count_d};
  assign live_d  = cnt_ext[LIVE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_id_q <= '0;
      timeout_q <= TIMEOUT_RESET;
      count_q   <= '0;
      rd_q      <= '0;
      keep_q    <= '0;
      rd_vld_q  <= 1'b0;
      match_q   <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == CFG_SELF_ID)) begin
        self_id_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_idx_i == CFG_TIMEOUT)) begin
        timeout_q <= cfg_wdata_i;
      end
      count_q  <= count_d;
      rd_q     <= rd_d;
      keep_q   <= keep_d;
      rd_vld_q <= rd_vld_d;
      match_q  <= match_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= command_i;
      id_q  <= node_id_i;
      now_q <= now_ms_i;
      ign_q <= (node_id_i == '0) || (node_id_i == self_id_q);
    end
    slot_q <= slot_d;
    if (ctrl_i.finish) begin
      outcome_q <= outcome_d;
      live_q    <= live_d;
    end
  end

  // Table storage: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ids_mem[wr_addr]  <= wr_id;
      seen_mem[wr_addr] <= wr_time;
    end
    if (issue) begin
      rd_id_q   <= ids_mem[rd_q[AW-1:0]];
      rd_time_q <= seen_mem[rd_q[AW-1:0]];
    end
  end

  assign done_o       = done_q;
  assign outcome_o    = outcome_q;
  assign live_count_o = live_q;

endmodule

// ===== rtl/neighbor_table_with_aging.sv =====
// Top level of the neighbor table with timeout aging.
//
//  Channel   Handshake            Payload
//  --------  -------------------  ---------------------------------
//  request   start & !busy        command_i, node_id_i, now_ms_i
//  result    done_o (one cycle)   outcome_o, live_count_o
//  config    cfg_we_i             cfg_idx_i, cfg_wdata_i
//
// A request runs from acceptance through the purge scan and the finish step to the result
// strobe; its duration is set by the single read port of the table, which the purge scan
// walks one entry a cycle. busy is high from the cycle after acceptance until the result
// cycle, in which the next request may already be accepted. Reset empties the table
// and loads self_id = 0 and timeout_ms = 10000. The result side takes every
// strobe as it comes.
module neighbor_table_with_aging #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            command_i,
  input  logic [ntab_pkg::ID_W-1:0]       node_id_i,
  input  logic [ntab_pkg::TIME_W-1:0]     now_ms_i,
  output logic                            done_o,
  output logic [ntab_pkg::OUTCOME_W-1:0]  outcome_o,
  output logic [ntab_pkg::LIVE_W-1:0]     live_count_o,
  input  logic                            cfg_we_i,
  input  logic [ntab_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ntab_pkg::CFG_W-1:0]      cfg_wdata_i
);
  import ntab_pkg::*;

  ntab_ctrl_t ctrl;
  ntab_stat_t stat;

  ntab_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  ntab_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .command_i    (command_i),
    .node_id_i    (node_id_i),
    .now_ms_i     (now_ms_i),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .done_o       (done_o),
    .outcome_o    (outcome_o),
    .live_count_o (live_count_o)
  );

endmodule

// ===== rtl/ntab_checker.sv =====
// Port-level checks for the neighbor table, attached to the top level by bind.
module ntab_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic                            done_o,
  input logic [ntab_pkg::OUTCOME_W-1:0]  outcome_o
);
  import ntab_pkg::*;

  // An accepted request keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // A result only follows a busy cycle.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a request in progress");

  // One strobe per request: never two in a row.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe lasted more than one cycle");

  // Only defined outcome codes appear.
  a_outcome_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (outcome_o == OUT_IGNORED) || (outcome_o == OUT_REFRESHED) ||
               (outcome_o == OUT_ADDED) || (outcome_o == OUT_DROPPED) ||
               (outcome_o == OUT_AGED))
    else $error("undefined outcome code");

endmodule

bind neighbor_table_with_aging ntab_checker u_ntab_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .done_o    (done_o),
  .outcome_o (outcome_o)
);
